/* hw/rtl/dgp_pkg.sv */
// Shared types and constants for the drifting grating pixel unit.
package dgp_pkg;

   localparam int SAMPLE_W = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Quarter-wave sine polynomial coefficients, unsigned Q1.15
   localparam logic [15:0] POLY_A = 16'd51472;
   localparam logic [15:0] POLY_B = 16'd21024;
   localparam logic [15:0] POLY_C = 16'd2320;

   localparam logic [14:0] Q15_MAX = 15'h7FFF;
   localparam sample_type  Q15_MIN = 16'sh8000;

   localparam logic [15:0] FREQ_RESET = 16'd4096;

endpackage

/* hw/rtl/dgp_sine.sv */
// Pipelined sine of an angle in turns: quadrant fold plus quarter-wave polynomial.
module dgp_sine #(
   parameter int TABLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [TABLE_BITS-1:0]  angle,
   output logic                   out_valid,
   output dgp_pkg::sample_type    out_value
);
   import dgp_pkg::*;

   localparam int FRAC_BITS = TABLE_BITS - 2;
   localparam int PAD_BITS  = 15 - FRAC_BITS;

   logic [1:0]           quad;
   logic [FRAC_BITS-1:0] frac;
   logic [15:0]          x_raw;

   logic [4:0]  valid_ff;
   logic [15:0] x_ff [1:4];
   logic        neg_ff [1:4];
   logic [15:0] x2_ff [2:3];
   logic [15:0] t1_ff;
   logic [15:0] t3_ff;
   sample_type  value_ff;

   logic [15:0] x_in;
   logic [31:0] xx_prod;
   logic [31:0] c_prod;
   logic [31:0] b_prod;
   logic [31:0] a_prod;
   logic [31:0] mag;
   logic [14:0] sat;
   logic [15:0] t1_in;
   logic [15:0] t3_in;
   sample_type  value_in;

   // stage 1: fold into the first quadrant
   assign quad  = angle[TABLE_BITS-1 -: 2];
   assign frac  = angle[FRAC_BITS-1:0];
   assign x_raw = {1'b0, frac, {PAD_BITS{1'b0}}};
   assign x_in  = quad[0] ? (16'h8000 - x_raw) : x_raw;

   // stage 2: x squared
   assign xx_prod = {16'd0, x_ff[1]} * {16'd0, x_ff[1]};

   // stage 3: B - C*x^2
   assign c_prod = {16'd0, POLY_C} * {16'd0, x2_ff[2]};
   assign t1_in  = 16'({16'd0, POLY_B} - (c_prod >> 15));

   // stage 4: A - x^2*(B - C*x^2)
   assign b_prod = {16'd0, t1_ff} * {16'd0, x2_ff[3]};
   assign t3_in  = 16'({16'd0, POLY_A} - (b_prod >> 15));

   // stage 5: times x, clamp, sign
   assign a_prod   = {16'd0, t3_ff} * {16'd0, x_ff[4]};
   assign mag      = a_prod >> 15;
   assign sat      = (mag > {17'd0, Q15_MAX}) ? Q15_MAX : mag[14:0];
   assign value_in = neg_ff[4] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[1]   <= x_in;
         neg_ff[1] <= quad[1];
         x2_ff[2]  <= xx_prod[30:15];
         x_ff[2]   <= x_ff[1];
         neg_ff[2] <= neg_ff[1];
         t1_ff     <= t1_in;
         x2_ff[3]  <= x2_ff[2];
         x_ff[3]   <= x_ff[2];
         neg_ff[3] <= neg_ff[2];
         t3_ff     <= t3_in;
         x_ff[4]   <= x_ff[3];
         neg_ff[4] <= neg_ff[3];
         value_ff  <= value_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_value = value_ff;

endmodule

/* hw/rtl/drifting_grating_pixel_unit.sv */
// Top level of the drifting grating pixel unit: phase pipeline and output buffering.
//
// One grating sample per pixel item: the unit forms the phase
// freq*((column+1)*sin(theta) - (row+1)*cos(theta) - speed*time), keeps the
// fraction of a cycle and returns its cosine as signed Q1.15 (-32767..32767).
// A new item is taken every clock cycle while req_ready is high. An accepted
// item reaches rsp_ through fifteen register stages, the first loaded by
// the accepting edge: one input register, a 5-stage sine/cosine polynomial
// pipeline, three stages for the products, the phase sum and the frequency
// scaling, a second 5-stage polynomial for the output cosine, and the output
// register. The whole pipeline moves as one; a one-item skid buffer behind it
// lets it keep taking items while a result waits on rsp_ready, and req_ready
// drops only once that buffer is full. csr_spatial_frequency (Q0.16, reset
// 4096) is always ready and is meant to be changed only while no item is in
// flight.
module drifting_grating_pixel_unit #(
   parameter int COORD_BITS = 10,
   parameter int TABLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel request items
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_BITS-1:0]  req_column,
   input  logic [COORD_BITS-1:0]  req_row,
   input  logic [15:0]            req_frame_time,
   input  logic [15:0]            req_orientation,
   input  logic signed [15:0]     req_drift_speed,
   // sample items
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dgp_pkg::sample_type    rsp_intensity,
   // spatial frequency register
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_spatial_frequency
);
   import dgp_pkg::*;

   localparam int CW = COORD_BITS + 1;   // column+1 / row+1 width
   localparam logic [TABLE_BITS-1:0] QUARTER = {2'b01, {(TABLE_BITS-2){1'b0}}};

   logic en;   // pipeline advance

   logic [15:0] freq_ff;

   // T0: input register
   logic                  v0_ff;
   logic [CW-1:0]         col0_ff, row0_ff;
   logic [15:0]           tim0_ff;
   logic signed [15:0]    spd0_ff;
   logic [TABLE_BITS-1:0] ang0_ff;

   // T1..T5: operands riding alongside the angle polynomials
   logic [CW-1:0] col_ff [1:5];
   logic [CW-1:0] row_ff [1:5];
   logic [27:0]   st_ff  [1:5];   // speed*time, low bits only (phase wraps)
   logic signed [33:0] st_full;

   logic       v5;
   sample_type sin_val, cos_val;

   // T6: products
   logic               v6_ff;
   logic signed [31:0] ps_ff, pc_ff, ps_in, pc_in;
   logic [27:0]        st6_ff;

   // T7: phase sum, wrapped to 31 bits
   logic        v7_ff;
   logic [30:0] sum_ff, sum_in;

   // T8: phase index
   logic                  v8_ff;
   logic [TABLE_BITS-1:0] idx_ff;
   logic [46:0]           prod;

   // output cosine
   logic       vlast;
   sample_type out_val;

   // output register and skid buffer
   logic       rsp_valid_ff;
   sample_type rsp_data_ff;
   logic       skid_full_ff;
   sample_type skid_data_ff;
   logic       take_last;
   logic       rsp_free;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_RESET;
      end else if (csr_valid && csr_ready) begin
         freq_ff <= csr_spatial_frequency;
      end
   end

   // ---------------- flow control ----------------
   // the pipeline stalls only when the skid entry is occupied
   assign en        = !skid_full_ff;
   assign req_ready = en;

   // ---------------- T0 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col0_ff <= {1'b0, req_column} + CW'(1);
         row0_ff <= {1'b0, req_row} + CW'(1);
         tim0_ff <= req_frame_time;
         spd0_ff <= req_drift_speed;
         ang0_ff <= req_orientation[15 -: TABLE_BITS];
      end
   end

   // ---------------- T1..T5 ----------------
   dgp_sine #(.TABLE_BITS(TABLE_BITS)) u_sin (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .angle     (ang0_ff),
      .out_valid (v5),
      .out_value (sin_val)
   );

   // cosine is the sine a quarter turn later
   dgp_sine #(.TABLE_BITS(TABLE_BITS)) u_cos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .angle     (ang0_ff + QUARTER),
      .out_valid (),
      .out_value (cos_val)
   );

   assign st_full = 34'(spd0_ff) * 34'($signed({1'b0, tim0_ff}));

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff[1] <= col0_ff;
         row_ff[1] <= row0_ff;
         st_ff[1]  <= st_full[27:0];
         for (int i = 2; i <= 5; i++) begin
            col_ff[i] <= col_ff[i-1];
            row_ff[i] <= row_ff[i-1];
            st_ff[i]  <= st_ff[i-1];
         end
      end
   end

   // ---------------- T6: coordinate products ----------------
   assign ps_in = 32'($signed({1'b0, col_ff[5]})) * 32'(sin_val);
   assign pc_in = 32'($signed({1'b0, row_ff[5]})) * 32'(cos_val);

   // ---------------- T7: phase sum (Q.15) ----------------
   // speed*time is Q.12, moved up by three bits
   assign sum_in = ps_ff[30:0] - pc_ff[30:0] - {st6_ff, 3'b000};

   // ---------------- T8: scale by frequency, take the cycle fraction ----
   assign prod = 47'(sum_ff) * 47'(freq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ps_ff  <= ps_in;
         pc_ff  <= pc_in;
         st6_ff <= st_ff[5];
         sum_ff <= sum_in;
         idx_ff <= prod[30 -: TABLE_BITS];
      end
   end

   // ---------------- output cosine ----------------
   dgp_sine #(.TABLE_BITS(TABLE_BITS)) u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v8_ff),
      .angle     (idx_ff + QUARTER),
      .out_valid (vlast),
      .out_value (out_val)
   );

   // ---------------- output register and skid ----------------
   // the last stage item leaves whenever the pipeline advances
   assign take_last = en && vlast;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         if (rsp_free) begin
            rsp_valid_ff <= skid_full_ff || take_last;
            skid_full_ff <= 1'b0;
         end else if (take_last) begin
            skid_full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_data_ff <= skid_full_ff ? skid_data_ff : out_val;
      end
      if (!rsp_free && take_last) begin
         skid_data_ff <= out_val;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_intensity = rsp_data_ff;

   // ---------------- assertions ----------------
   // skid holds an item only behind a waiting output item
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid entry occupied with empty output register");

   // skid fills only from a stalled output
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid filled without an output stall");

   // no new item while the skid entry is occupied
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> !req_ready)
      else $error("item accepted with skid entry occupied");

   // cosine output is clamped to the symmetric Q1.15 range
   a_no_min_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff != Q15_MIN)
      else $error("intensity outside symmetric range");

endmodule
